>>> hw/rtl/owm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and codes for the single-wire bus master: command modes,
// register indexes, sequencer phases and the config and result records.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TICK_W     = 10;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_RESET = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_RESET_RECOVER = 3'd2,
        CFG_SHORT_LOW     = 3'd3,
        CFG_SLOT          = 3'd4,
        CFG_READ_WAIT     = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_RST_LOW     = 3'd1,
        PH_RST_WAIT    = 3'd2,
        PH_RST_RECOVER = 3'd3,
        PH_WR_LOW      = 3'd4,
        PH_WR_REL      = 3'd5,
        PH_RD_LOW      = 3'd6,
        PH_RD_WAIT     = 3'd7
    } t_phase;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [9:0] presence_wait_us;
        logic [9:0] reset_recover_us;
        logic [3:0] short_low_us;
        logic [6:0] slot_us;
        logic [6:0] read_wait_us;
    } t_cfg;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } t_result;

endpackage

>>> hw/rtl/owm_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_cfg_regs
// Timing register file of the bus master, written through a plain write port.
// ----------------------------------------------------------------------------
module owm_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [owm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output owm_pkg::t_cfg                    o_cfg
);

    owm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_us     <= 10'd500;
            r_cfg.presence_wait_us <= 10'd80;
            r_cfg.reset_recover_us <= 10'd500;
            r_cfg.short_low_us     <= 4'd2;
            r_cfg.slot_us          <= 7'd60;
            r_cfg.read_wait_us     <= 7'd50;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                owm_pkg::CFG_RESET_LOW:     r_cfg.reset_low_us     <= i_cfg_data;
                owm_pkg::CFG_PRESENCE_WAIT: r_cfg.presence_wait_us <= i_cfg_data;
                owm_pkg::CFG_RESET_RECOVER: r_cfg.reset_recover_us <= i_cfg_data;
                owm_pkg::CFG_SHORT_LOW:     r_cfg.short_low_us     <= i_cfg_data[3:0];
                owm_pkg::CFG_SLOT:          r_cfg.slot_us          <= i_cfg_data[6:0];
                owm_pkg::CFG_READ_WAIT:     r_cfg.read_wait_us     <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/owm_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_engine
// Bus sequencer: phase machine, tick counter, bit shifter and status flags.
// Updates once per accepted request and presents the resulting status.
// ----------------------------------------------------------------------------
module owm_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_write_data,
    input  logic              i_line_level,
    input  owm_pkg::t_cfg     i_cfg,
    output owm_pkg::t_result  o_result
);

    owm_pkg::t_phase r_phase, n_phase;
    logic [owm_pkg::TICK_W-1:0] r_tick_count, n_tick_count;
    logic [2:0] r_bit_index, n_bit_index;
    logic [7:0] r_shift_byte, n_shift_byte;
    logic       r_presence, n_presence;
    logic       r_line_driven, n_line_driven;
    logic [7:0] r_last_read, n_last_read;

    logic [owm_pkg::TICK_W-1:0] tc1;
    logic [9:0] thr_rst_low, thr_pres;
    logic [3:0] thr_short;
    logic [6:0] thr_slot;
    logic [7:0] thr_read;
    logic       is_tick, busy, adv, hit, last_bit, recover_zero;
    logic       bit_end, done;
    logic [7:0] rd_byte;

    always_comb begin
        tc1          = r_tick_count + 10'd1;
        thr_rst_low  = (i_cfg.reset_low_us == 10'd0) ? 10'd1 : i_cfg.reset_low_us;
        thr_pres     = (i_cfg.presence_wait_us == 10'd0) ? 10'd1 : i_cfg.presence_wait_us;
        thr_short    = (i_cfg.short_low_us == 4'd0) ? 4'd1 : i_cfg.short_low_us;
        thr_slot     = (i_cfg.slot_us == 7'd0) ? 7'd1 : i_cfg.slot_us;
        thr_read     = {1'b0, i_cfg.read_wait_us} + 8'd1;
        recover_zero = (i_cfg.reset_recover_us == 10'd0);
        is_tick      = (i_mode == owm_pkg::MODE_TICK);
        busy         = (r_phase != owm_pkg::PH_IDLE);
        adv          = is_tick && busy;
        last_bit     = (r_bit_index == 3'd7);
        unique case (r_phase)
            owm_pkg::PH_RST_LOW:     hit = tc1 >= thr_rst_low;
            owm_pkg::PH_RST_WAIT:    hit = tc1 >= thr_pres;
            owm_pkg::PH_RST_RECOVER: hit = tc1 >= i_cfg.reset_recover_us;
            owm_pkg::PH_WR_LOW:      hit = r_shift_byte[0] ? (tc1 >= {6'd0, thr_short})
                                                           : (tc1 >= {3'd0, thr_slot});
            owm_pkg::PH_WR_REL:      hit = tc1 >= {3'd0, thr_slot};
            owm_pkg::PH_RD_LOW:      hit = tc1 >= {6'd0, thr_short};
            owm_pkg::PH_RD_WAIT:     hit = tc1 >= {2'd0, thr_read};
            default:                 hit = 1'b0;
        endcase
        // bit slot finishes on this tick
        bit_end = hit && ((r_phase == owm_pkg::PH_WR_LOW && !r_shift_byte[0])
                          || r_phase == owm_pkg::PH_WR_REL
                          || r_phase == owm_pkg::PH_RD_WAIT);
        rd_byte = r_shift_byte;
        if (r_phase == owm_pkg::PH_RD_WAIT && tc1 == 10'd1 && i_line_level) begin
            rd_byte[r_bit_index] = 1'b1;
        end
        done = adv && hit && ((r_phase == owm_pkg::PH_RST_WAIT && recover_zero)
                              || r_phase == owm_pkg::PH_RST_RECOVER
                              || (bit_end && last_bit));
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_en) begin
            if (adv && hit) begin
                unique case (r_phase)
                    owm_pkg::PH_RST_LOW:     n_phase = owm_pkg::PH_RST_WAIT;
                    owm_pkg::PH_RST_WAIT:    n_phase = recover_zero ? owm_pkg::PH_IDLE
                                                                    : owm_pkg::PH_RST_RECOVER;
                    owm_pkg::PH_RST_RECOVER: n_phase = owm_pkg::PH_IDLE;
                    owm_pkg::PH_WR_LOW: begin
                        if (r_shift_byte[0]) n_phase = owm_pkg::PH_WR_REL;
                        else n_phase = last_bit ? owm_pkg::PH_IDLE : owm_pkg::PH_WR_LOW;
                    end
                    owm_pkg::PH_WR_REL:  n_phase = last_bit ? owm_pkg::PH_IDLE
                                                            : owm_pkg::PH_WR_LOW;
                    owm_pkg::PH_RD_LOW:  n_phase = owm_pkg::PH_RD_WAIT;
                    owm_pkg::PH_RD_WAIT: n_phase = last_bit ? owm_pkg::PH_IDLE
                                                            : owm_pkg::PH_RD_LOW;
                    default: n_phase = r_phase;
                endcase
            end else if (!is_tick && !busy) begin
                unique case (i_mode)
                    owm_pkg::MODE_RESET: n_phase = owm_pkg::PH_RST_LOW;
                    owm_pkg::MODE_WRITE: n_phase = owm_pkg::PH_WR_LOW;
                    owm_pkg::MODE_READ:  n_phase = owm_pkg::PH_RD_LOW;
                    default:             n_phase = r_phase;
                endcase
            end
        end
    end

    // counters, shifter and flags
    always_comb begin
        n_tick_count  = r_tick_count;
        n_bit_index   = r_bit_index;
        n_shift_byte  = r_shift_byte;
        n_presence    = r_presence;
        n_line_driven = r_line_driven;
        n_last_read   = r_last_read;
        if (i_en) begin
            if (adv) begin
                n_tick_count = hit ? '0 : tc1;
                if (r_phase == owm_pkg::PH_RD_WAIT) begin
                    n_shift_byte = rd_byte;
                end
                if (hit) begin
                    if (bit_end) begin
                        n_bit_index   = last_bit ? 3'd0 : r_bit_index + 3'd1;
                        n_line_driven = !last_bit;
                        if (r_phase == owm_pkg::PH_RD_WAIT) begin
                            if (last_bit) n_last_read = rd_byte;
                        end else if (!last_bit) begin
                            n_shift_byte = {1'b0, r_shift_byte[7:1]};
                        end
                    end else begin
                        n_line_driven = 1'b0;
                    end
                    if (r_phase == owm_pkg::PH_RST_WAIT) begin
                        n_presence = !i_line_level;
                    end
                end
            end else if (!is_tick && !busy) begin
                n_tick_count  = '0;
                n_bit_index   = 3'd0;
                n_line_driven = 1'b1;
                if (i_mode == owm_pkg::MODE_WRITE) n_shift_byte = i_write_data;
                else if (i_mode == owm_pkg::MODE_READ) n_shift_byte = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= owm_pkg::PH_IDLE;
            r_tick_count  <= '0;
            r_bit_index   <= 3'd0;
            r_shift_byte  <= 8'd0;
            r_presence    <= 1'b0;
            r_line_driven <= 1'b0;
            r_last_read   <= 8'd0;
        end else begin
            r_phase       <= n_phase;
            r_tick_count  <= n_tick_count;
            r_bit_index   <= n_bit_index;
            r_shift_byte  <= n_shift_byte;
            r_presence    <= n_presence;
            r_line_driven <= n_line_driven;
            r_last_read   <= n_last_read;
        end
    end

    // status after this request
    always_comb begin
        o_result.drive_low = n_line_driven;
        o_result.busy_res  = (n_phase != owm_pkg::PH_IDLE);
        o_result.done_res  = done;
        o_result.presence  = n_presence;
        o_result.read_data = n_last_read;
        o_result.rejected  = !is_tick && busy;
    end

endmodule

>>> hw/rtl/owm_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_out_buf
// Result register with a skid entry; takes a new result while one waits.
// ----------------------------------------------------------------------------
module owm_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  owm_pkg::t_result  i_data,
    input  logic              i_stall,
    output logic              o_full,
    output logic              o_valid,
    output owm_pkg::t_result  o_data
);

    logic             r_main_valid, r_skid_valid;
    owm_pkg::t_result r_main, r_skid;
    logic             pop;

    assign pop = r_main_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) r_skid_valid <= 1'b1;
            else r_main_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) r_main <= r_skid;
            else if (i_push) r_main <= i_data;
        end else if (i_push) begin
            if (r_main_valid) r_skid <= i_data;
            else r_main <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

>>> hw/rtl/one_wire_bus_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Single-wire bus master: reset with presence detect, byte write, byte read.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): each request is either a 1 us tick with
// the sampled line level (mode tick) or a command given while idle: reset,
// write byte or read byte. A command while busy is ignored and flagged.
// Output channel (o_valid / i_stall): one status result per request, with
// line drive, busy, done, presence, last read byte and rejected flag.
// Each result is registered in the output buffer when its request is taken.
// Throughput: one request per cycle while o_stall is low; the sequencer state
// updates per request, so the timing registers and phase counter set no limit.
// A two-entry output buffer holds results while the receiver stalls; the
// block stalls its input only once both entries are full.
// Reset: the line is released, the sequencer is idle, presence and read byte
// clear and the timing registers return to 500/80/500/2/60/50 us. The user
// writes timing registers via i_cfg_we while idle; the block does not check.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [owm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_mode,
    input  logic [7:0]                       i_write_data,
    input  logic                             i_line_level,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_drive_low,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic                             o_presence,
    output logic [7:0]                       o_read_data,
    output logic                             o_rejected
);

    owm_pkg::t_cfg    cfg;
    owm_pkg::t_result eng_result, out_result;
    logic             buf_full, push;

    assign push    = i_valid && !buf_full;
    assign o_stall = buf_full;

    owm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    owm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (push),
        .i_mode       (i_mode),
        .i_write_data (i_write_data),
        .i_line_level (i_line_level),
        .i_cfg        (cfg),
        .o_result     (eng_result)
    );

    owm_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (eng_result),
        .i_stall (i_stall),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (out_result)
    );

    assign o_drive_low = out_result.drive_low;
    assign o_busy_res  = out_result.busy_res;
    assign o_done_res  = out_result.done_res;
    assign o_presence  = out_result.presence;
    assign o_read_data = out_result.read_data;
    assign o_rejected  = out_result.rejected;

endmodule
